// File: rtl/bcdt_pkg.sv
// bcdt_pkg: shared types and constants for the BCD countdown timer.
// Used by bcdt_digit_cell and bcd_countdown_timer_top. No dependencies.
package bcdt_pkg;

    localparam int NDIG = 6;

    typedef logic [3:0] bcd_t;
    typedef logic [4:0] entry_digit_t;   // bit 4 marks the digit unset

    localparam entry_digit_t DIGIT_UNSET = 5'h10;

    // item kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CHAR   = 3'd1;
    localparam logic [2:0] KIND_FINISH = 3'd2;
    localparam logic [2:0] KIND_PAUSE  = 3'd3;
    localparam logic [2:0] KIND_RELOAD = 3'd4;

    // set error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd2;
    localparam logic [1:0] ERR_ZERO     = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam bcd_t WRAP_TENS = 4'd5;
    localparam bcd_t WRAP_ONES = 4'd9;

    // controls common to every cell of the row
    typedef struct packed {
        logic load;          // load count from load_val
        logic entry_clear;   // mark entry digit unset
        logic reload_copy;   // copy entry digit into reload copy
    } cell_ctrl_t;

endpackage

// File: rtl/bcdt_digit_cell.sv
// bcdt_digit_cell: one BCD digit of the count, its entry digit and reload copy.
// Borrow ripples in from the less significant neighbour. Depends on bcdt_pkg.
module bcdt_digit_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bcdt_pkg::cell_ctrl_t  ctrl,
    input  bcdt_pkg::bcd_t        wrap_digit,
    input  bcdt_pkg::bcd_t        load_val,
    input  logic                  borrow_in,
    input  logic                  entry_wr,
    input  bcdt_pkg::bcd_t        entry_val,
    output bcdt_pkg::bcd_t        count,
    output bcdt_pkg::entry_digit_t entry,
    output bcdt_pkg::entry_digit_t reload,
    output logic                  borrow_out
);
    import bcdt_pkg::*;

    bcd_t         count_reg,  count_next;
    entry_digit_t entry_reg,  entry_next;
    entry_digit_t reload_reg, reload_next;

    assign borrow_out = borrow_in && (count_reg == 4'd0);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = load_val;
        end
        else if (borrow_in)
        begin
            count_next = (count_reg == 4'd0) ? wrap_digit : count_reg - 4'd1;
        end

        entry_next = entry_reg;
        if (ctrl.entry_clear)
        begin
            entry_next = DIGIT_UNSET;
        end
        else if (entry_wr)
        begin
            entry_next = {1'b0, entry_val};
        end

        reload_next = ctrl.reload_copy ? entry_reg : reload_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 4'd0;
            entry_reg  <= DIGIT_UNSET;
            reload_reg <= DIGIT_UNSET;
        end
        else
        begin
            count_reg  <= count_next;
            entry_reg  <= entry_next;
            reload_reg <= reload_next;
        end
    end

    assign count  = count_reg;
    assign entry  = entry_reg;
    assign reload = reload_reg;

endmodule

// File: rtl/bcd_countdown_timer_top.sv
// bcd_countdown_timer_top: six-digit BCD hh:mm:ss countdown with character entry.
// Each result word is registered and valid in the cycle after its word is accepted.
// Throughput one word per cycle unless m_tready stalls; the cell borrow ripple is combinational.
// Reset (rst_n, async, active low): count zero, entry and reload digits unset,
// not paused, no error, output empty. Depends on bcdt_pkg and bcdt_digit_cell.
module bcd_countdown_timer_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic [2:0]  s_tuser,    // [2:0] kind
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [3:0] hour_tens, [7:4] hour_ones,
                                    // [11:8] minute_tens, [15:12] minute_ones,
                                    // [19:16] second_tens, [23:20] second_ones,
                                    // [24] at_zero, [25] is_paused,
                                    // [27:26] set_error, [31:28] zero
);
    import bcdt_pkg::*;

    // ---------------------------------------------------------------------
    // Control state: entry cursor, latched entry error, pause, result slot
    // ---------------------------------------------------------------------
    logic [2:0] pos_reg,        pos_next;
    logic [1:0] group_left_reg, group_left_next;
    logic [1:0] entry_err_reg,  entry_err_next;
    logic       paused_reg,     paused_next;
    logic [1:0] report_reg,     report_next;
    logic       out_valid_reg,  out_valid_next;

    logic       accept;
    logic [2:0] kind;
    logic [7:0] char_code;

    // row of digit cells, index 0 = hour tens ... 5 = second ones
    cell_ctrl_t   cell_ctrl;
    bcd_t         count     [NDIG];
    entry_digit_t entry     [NDIG];
    entry_digit_t reload    [NDIG];
    bcd_t         load_val  [NDIG];
    entry_digit_t load_src  [NDIG];
    logic         entry_wr  [NDIG];
    logic         borrow    [NDIG+1];   // borrow[i+1] feeds cell i
                                        // borrow[0] stays low: no tick at zero

    logic       count_zero;
    logic       load_zero;
    logic       dec_en;
    logic       is_digit;
    logic       load_from_reload;
    logic [3:0] colon_pos;
    bcd_t       char_val;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign kind      = s_tuser;
    assign char_code = s_tdata;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign char_val = 4'(char_code - CHAR_ZERO);

    always_comb
    begin
        count_zero = 1'b1;
        load_zero  = 1'b1;
        for (int i = 0; i < NDIG; i++)
        begin
            if (count[i] != 4'd0)
            begin
                count_zero = 1'b0;
            end
            if (load_val[i] != 4'd0)
            begin
                load_zero = 1'b0;
            end
        end
    end

    // decrement enters at the seconds ones cell and ripples up
    assign dec_en       = accept && (kind == KIND_TICK) && !paused_reg && !count_zero;
    assign borrow[NDIG] = dec_en;

    // Load source: reload copy for a reload word, entry digits for a finish.
    // A group with its ones digit unset takes its only digit as ones.
    assign load_from_reload = (kind == KIND_RELOAD);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            load_src[i] = load_from_reload ? reload[i] : entry[i];
        end
        for (int g = 0; g < NDIG; g += 2)
        begin
            if (load_src[g+1][4])
            begin
                load_val[g]   = 4'd0;
                load_val[g+1] = load_src[g][4] ? 4'd0 : load_src[g][3:0];
            end
            else
            begin
                load_val[g]   = load_src[g][3:0];
                load_val[g+1] = load_src[g+1][3:0];
            end
        end
    end

    assign colon_pos = {1'b0, pos_reg} + {2'b00, group_left_reg};

    always_comb
    begin
        pos_next        = pos_reg;
        group_left_next = group_left_reg;
        entry_err_next  = entry_err_reg;
        paused_next     = paused_reg;
        report_next     = report_reg;
        out_valid_next  = out_valid_reg;
        cell_ctrl       = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            entry_wr[i] = 1'b0;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            case (kind)
                KIND_CHAR:
                begin
                    if (entry_err_reg == ERR_NONE)
                    begin
                        if (is_digit)
                        begin
                            if ((group_left_reg == 2'd0) || (pos_reg >= 3'(NDIG)))
                            begin
                                entry_err_next = ERR_TOO_MANY;
                            end
                            else
                            begin
                                for (int i = 0; i < NDIG; i++)
                                begin
                                    entry_wr[i] = (pos_reg == 3'(i));
                                end
                                pos_next        = pos_reg + 3'd1;
                                group_left_next = group_left_reg - 2'd1;
                            end
                        end
                        else if (char_code == CHAR_COLON)
                        begin
                            pos_next = (colon_pos > 4'(NDIG)) ? 3'(NDIG) : colon_pos[2:0];
                            group_left_next = 2'd2;
                        end
                        else
                        begin
                            entry_err_next = ERR_BAD_CHAR;
                        end
                    end
                end
                KIND_FINISH:
                begin
                    if (entry_err_reg == ERR_NONE)
                    begin
                        cell_ctrl.load        = 1'b1;
                        cell_ctrl.reload_copy = 1'b1;
                    end
                    cell_ctrl.entry_clear = 1'b1;
                    pos_next              = 3'd0;
                    group_left_next       = 2'd2;
                    entry_err_next        = ERR_NONE;
                end
                KIND_PAUSE:
                begin
                    paused_next = !paused_reg;
                end
                KIND_RELOAD:
                begin
                    cell_ctrl.load = 1'b1;
                end
                default:
                begin
                end
            endcase

            // report: outcome of a finish, else the error latched so far
            if (kind == KIND_FINISH)
            begin
                if (entry_err_reg != ERR_NONE)
                begin
                    report_next = entry_err_reg;
                end
                else
                begin
                    report_next = load_zero ? ERR_ZERO : ERR_NONE;
                end
            end
            else
            begin
                report_next = entry_err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= 3'd0;
            group_left_reg <= 2'd2;
            entry_err_reg  <= ERR_NONE;
            paused_reg     <= 1'b0;
            report_reg     <= ERR_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            group_left_reg <= group_left_next;
            entry_err_reg  <= entry_err_next;
            paused_reg     <= paused_next;
            report_reg     <= report_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------------
    // Digit cell row: tens cells wrap to 5, ones cells to 9
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        if (i == 0)
        begin : g_msd
            bcdt_digit_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .wrap_digit (WRAP_TENS),
                .load_val   (load_val[i]),
                .borrow_in  (borrow[i+1]),
                .entry_wr   (entry_wr[i]),
                .entry_val  (char_val),
                .count      (count[i]),
                .entry      (entry[i]),
                .reload     (reload[i]),
                .borrow_out (borrow[i])
            );
        end
        else
        begin : g_lsd
            bcdt_digit_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .wrap_digit ((i % 2 == 0) ? WRAP_TENS : WRAP_ONES),
                .load_val   (load_val[i]),
                .borrow_in  (borrow[i+1]),
                .entry_wr   (entry_wr[i]),
                .entry_val  (char_val),
                .count      (count[i]),
                .entry      (entry[i]),
                .reload     (reload[i]),
                .borrow_out (borrow[i])
            );
        end
    end

    // State changes only on an accepted word, so the result word is read
    // straight from the state registers and holds while stalled.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, report_reg, paused_reg, count_zero,
                       count[5], count[4], count[3], count[2], count[1], count[0]};

endmodule
